// File: rtl/core/mspk_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and sizes of the two-motor speed loop
package mspk_pkg;

  localparam int NUM_MOTORS  = 2;
  localparam int SCALE_SHIFT = 8;
  localparam int KICK_DELTA  = 100;

  localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN     = 3'd0,
    CFG_I_GAIN     = 3'd1,
    CFG_INT_LIMIT  = 3'd2,
    CFG_CMP_MIN    = 3'd3,
    CFG_CMP_MAX    = 3'd4,
    CFG_STILL_LIM  = 3'd5,
    CFG_KICK_MAX   = 3'd6,
    CFG_MOTOR_MODE = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_CAPTURE = 2'd0,
    REQ_CONTROL = 2'd1,
    REQ_TICK    = 2'd2
  } req_e;

  typedef struct packed {
    logic [15:0] p_gain;
    logic [15:0] i_gain;
    logic [30:0] int_limit;
    logic [15:0] cmp_min;
    logic [15:0] cmp_max;
    logic [15:0] still_lim;
    logic [15:0] kick_max;
    logic [3:0]  mode;
  } cfg_t;

  // one memory word per motor
  typedef struct packed {
    logic [15:0]        last_edge;
    logic [15:0]        period;
    logic signed [31:0] position;
    logic signed [31:0] integral;
    logic [15:0]        compare;
    logic               spinning;
    logic [31:0]        old_pos;
    logic [15:0]        still;
  } rec_t;

  typedef struct packed {
    logic               motor;
    logic               do_pi;
    rec_t               rec;
    logic signed [32:0] prod_p;
    logic signed [32:0] prod_i;
  } s2_t;

  typedef struct packed {
    logic               motor;
    logic               do_pi;
    rec_t               rec;
    logic signed [32:0] prod_p;
    logic signed [31:0] integ;
  } s3_t;

endpackage

// File: rtl/core/motor_speed_pi_with_stall_kick_core.sv
`timescale 1ns / 1ps
// top level of the two-motor pi speed loop with standstill kick
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: timestamp, desired_period
//                                                tuser: req_type, motor
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: compare_value,
//                                                measured_period, position, spinning
//                                                tuser: motor_out
//  cfg       in   cfg_we_i (no back-pressure)    cfg_idx_i, cfg_wdata_i
//
// from accept to m_axis_tvalid a word passes the memory read together with the
// request capture, then update and products, integral clamp, and
// shift/clamp with write-back into the output word
// words for different motors enter in consecutive cycles unless the output stalls; a
// word for a motor that still has an earlier word in flight waits for its write-back,
// so the spacing of words for the same motor is set by the read-modify-write loop
// reset clears per-entry valid bits at once, no clearing pass
// a stalled output word holds while up to two more words, one per motor, wait behind it
module motor_speed_pi_with_stall_kick_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] timestamp, [31:16] desired_period
  input  logic [mspk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] req_type, [2] motor
  input  logic [mspk_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] compare_value, [31:16] measured_period, [63:32] position,
  // [64] spinning, [71:65] zero
  output logic [mspk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] motor_out
  output logic [mspk_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [mspk_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mspk_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import mspk_pkg::*;

  cfg_t  cfg;
  rec_t  rd_rec;
  rec_t  fin_rec;
  s2_t   s2;
  logic  s1_motor;
  logic  s3_motor;

  // stage valids: s1 update, s2 integral, s3 final, output word
  logic  v1_q, v2_q, v3_q, vo_q;
  logic  out_ld, adv2, adv1, accept;
  logic  in_motor;
  logic  conflict;
  logic  out_motor_q;
  rec_t  out_rec_q;

  // motor index folds onto the motors that exist
  assign in_motor = (NUM_MOTORS > 1) ? s_axis_tuser[2] : 1'b0;

  // back-pressure chain from the output word back to the input
  assign out_ld = v3_q && (!vo_q || m_axis_tready);
  assign adv2   = v2_q && (!v3_q || out_ld);
  assign adv1   = v1_q && (!v2_q || adv2);

  // interlock: one word per motor in the read-modify-write loop
  assign conflict = (v1_q && (s1_motor == in_motor)) ||
                    (v2_q && (s2.motor == in_motor)) ||
                    (v3_q && (s3_motor == in_motor));

  assign s_axis_tready = (!v1_q || adv1) && !conflict;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (adv1) begin
        v2_q <= 1'b1;
      end else if (adv2) begin
        v2_q <= 1'b0;
      end
      if (adv2) begin
        v3_q <= 1'b1;
      end else if (out_ld) begin
        v3_q <= 1'b0;
      end
      if (out_ld) begin
        vo_q <= 1'b1;
      end else if (m_axis_tready) begin
        vo_q <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_motor_q <= s3_motor;
      out_rec_q   <= fin_rec;
    end
  end

  mspk_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mspk_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (MIDX_W'(in_motor)),
    .rd_data_o (rd_rec),
    .wr_en_i   (out_ld),
    .wr_idx_i  (MIDX_W'(s3_motor)),
    .wr_data_i (fin_rec)
  );

  mspk_update u_upd (
    .clk_i      (clk_i),
    .acc_i      (accept),
    .req_i      (s_axis_tuser[1:0]),
    .motor_i    (in_motor),
    .ts_i       (s_axis_tdata[15:0]),
    .desired_i  (s_axis_tdata[31:16]),
    .rd_rec_i   (rd_rec),
    .cfg_i      (cfg),
    .adv_i      (adv1),
    .s1_motor_o (s1_motor),
    .s2_o       (s2)
  );

  mspk_pi u_pi (
    .clk_i      (clk_i),
    .ld3_i      (adv2),
    .s2_i       (s2),
    .cfg_i      (cfg),
    .s3_motor_o (s3_motor),
    .fin_rec_o  (fin_rec)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {7'b0, out_rec_q.spinning, out_rec_q.position,
                          out_rec_q.period, out_rec_q.compare};
  assign m_axis_tuser  = out_motor_q;

endmodule

// File: rtl/core/mspk_cfg.sv
`timescale 1ns / 1ps
// configuration register file
module mspk_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mspk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mspk_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output mspk_pkg::cfg_t                  cfg_o
);
  import mspk_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cmp_max: 16'hFFFF, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_P_GAIN:     cfg_q.p_gain    <= cfg_wdata_i[15:0];
        CFG_I_GAIN:     cfg_q.i_gain    <= cfg_wdata_i[15:0];
        CFG_INT_LIMIT:  cfg_q.int_limit <= cfg_wdata_i[30:0];
        CFG_CMP_MIN:    cfg_q.cmp_min   <= cfg_wdata_i[15:0];
        CFG_CMP_MAX:    cfg_q.cmp_max   <= cfg_wdata_i[15:0];
        CFG_STILL_LIM:  cfg_q.still_lim <= cfg_wdata_i[15:0];
        CFG_KICK_MAX:   cfg_q.kick_max  <= cfg_wdata_i[15:0];
        CFG_MOTOR_MODE: cfg_q.mode      <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/mspk_state_mem.sv
`timescale 1ns / 1ps
// per-motor state memory, registered read, valid bit per entry
module mspk_state_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [mspk_pkg::MIDX_W-1:0] rd_idx_i,
  output mspk_pkg::rec_t              rd_data_o,
  input  logic                        wr_en_i,
  input  logic [mspk_pkg::MIDX_W-1:0] wr_idx_i,
  input  mspk_pkg::rec_t              wr_data_i
);
  import mspk_pkg::*;

  rec_t                  mem [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] vld_q;
  rec_t                  rd_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rd_q : '0;

endmodule

// File: rtl/core/mspk_update.sv
`timescale 1ns / 1ps
// first stage: event update of the state word and the two gain products
module mspk_update (
  input  logic           clk_i,
  input  logic           acc_i,
  input  logic [1:0]     req_i,
  input  logic           motor_i,
  input  logic [15:0]    ts_i,
  input  logic [15:0]    desired_i,
  input  mspk_pkg::rec_t rd_rec_i,
  input  mspk_pkg::cfg_t cfg_i,
  input  logic           adv_i,
  output logic           s1_motor_o,
  output mspk_pkg::s2_t  s2_o
);
  import mspk_pkg::*;

  logic [1:0]         req_q;
  logic               motor_q;
  logic [15:0]        ts_q;
  logic [15:0]        desired_q;
  s2_t                s2_q;

  rec_t               rec_n;
  logic               do_pi;
  logic [1:0]         mode;
  logic [15:0]        still_inc;
  logic [16:0]        kick_top;
  logic [16:0]        kick_c;
  logic signed [16:0] err;
  logic signed [32:0] prod_p;
  logic signed [32:0] prod_i;

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      req_q     <= req_i;
      motor_q   <= motor_i;
      ts_q      <= ts_i;
      desired_q <= desired_i;
    end
    if (adv_i) begin
      s2_q <= '{motor: motor_q, do_pi: do_pi, rec: rec_n, prod_p: prod_p, prod_i: prod_i};
    end
  end

  assign mode = motor_q ? cfg_i.mode[3:2] : cfg_i.mode[1:0];

  assign err    = $signed({1'b0, rd_rec_i.period}) - $signed({1'b0, desired_q});
  assign prod_p = 33'(err) * 33'($signed({1'b0, cfg_i.p_gain}));
  assign prod_i = 33'(err) * 33'($signed({1'b0, cfg_i.i_gain}));

  always_comb begin
    rec_n     = rd_rec_i;
    do_pi     = 1'b0;
    still_inc = (rd_rec_i.still != 16'hFFFF) ? rd_rec_i.still + 16'd1 : rd_rec_i.still;
    kick_top  = {1'b0, cfg_i.kick_max} + 17'(KICK_DELTA);
    kick_c    = {1'b0, rd_rec_i.compare};
    unique case (req_q)
      REQ_CAPTURE: begin
        rec_n.period    = ts_q - rd_rec_i.last_edge;
        rec_n.last_edge = ts_q;
        rec_n.position  = mode[1] ? rd_rec_i.position - 32'sd1
                                  : rd_rec_i.position + 32'sd1;
      end
      REQ_CONTROL: begin
        if (rd_rec_i.spinning && mode[0]) begin
          do_pi = 1'b1;
        end else begin
          rec_n.integral = '0;
        end
      end
      REQ_TICK: begin
        if ((rd_rec_i.position == $signed(rd_rec_i.old_pos)) && mode[0]) begin
          rec_n.still = still_inc;
          if (still_inc > cfg_i.still_lim) begin
            // standstill: drop spinning and integral, kick the compare
            rec_n.spinning = 1'b0;
            rec_n.integral = '0;
            if (kick_c > kick_top) begin
              kick_c = {1'b0, cfg_i.kick_max};
            end
            if (kick_c <= {1'b0, cfg_i.kick_max}) begin
              kick_c = kick_c + 17'(KICK_DELTA);
              if (kick_c[16]) begin
                kick_c = 17'h0FFFF;
              end
            end
            rec_n.compare = kick_c[15:0];
          end
        end else begin
          rec_n.still    = '0;
          rec_n.old_pos  = rd_rec_i.position;
          rec_n.spinning = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s1_motor_o = motor_q;
  assign s2_o       = s2_q;

endmodule

// File: rtl/core/mspk_pi.sv
`timescale 1ns / 1ps
// pi tail: integral clamp, then sum, floor shift and compare clamp
module mspk_pi (
  input  logic           clk_i,
  input  logic           ld3_i,
  input  mspk_pkg::s2_t  s2_i,
  input  mspk_pkg::cfg_t cfg_i,
  output logic           s3_motor_o,
  output mspk_pkg::rec_t fin_rec_o
);
  import mspk_pkg::*;

  s3_t                s3_q;
  logic signed [33:0] ii;
  logic signed [33:0] lim;
  logic signed [31:0] integ;
  logic signed [33:0] sum;
  logic signed [33:0] shv;
  logic signed [33:0] cval;
  rec_t               rec_f;

  assign lim = $signed({3'b000, cfg_i.int_limit});
  assign ii  = {s2_i.prod_i[32], s2_i.prod_i}
             + {{2{s2_i.rec.integral[31]}}, s2_i.rec.integral};

  always_comb begin
    if (ii > lim) begin
      integ = lim[31:0];
    end else if (ii < -lim) begin
      integ = 32'(-lim);
    end else begin
      integ = ii[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3_i) begin
      s3_q <= '{motor: s2_i.motor, do_pi: s2_i.do_pi, rec: s2_i.rec,
                prod_p: s2_i.prod_p, integ: integ};
    end
  end

  assign sum = {s3_q.prod_p[32], s3_q.prod_p} + {{2{s3_q.integ[31]}}, s3_q.integ};
  assign shv = sum >>> SCALE_SHIFT;

  always_comb begin
    cval = shv;
    if (cval > $signed({18'b0, cfg_i.cmp_max})) begin
      cval = $signed({18'b0, cfg_i.cmp_max});
    end
    if (cval < $signed({18'b0, cfg_i.cmp_min})) begin
      cval = $signed({18'b0, cfg_i.cmp_min});
    end
    rec_f = s3_q.rec;
    if (s3_q.do_pi) begin
      rec_f.compare  = cval[15:0];
      rec_f.integral = s3_q.integ;
    end
  end

  assign s3_motor_o = s3_q.motor;
  assign fin_rec_o  = rec_f;

endmodule

// File: rtl/core/mspk_checker.sv
`timescale 1ns / 1ps
// port-level checks of the speed loop core and their bind
module mspk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [mspk_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mspk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [mspk_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import mspk_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // words inside the core
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 3'd0)
    else $error("output word without an accepted input word");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> cnt_q < 3'd4)
    else $error("more words accepted than the pipeline holds");

  a_same_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !(in_acc && (s_axis_tuser[2] == $past(s_axis_tuser[2]))))
    else $error("same motor accepted in consecutive cycles");

endmodule

bind motor_speed_pi_with_stall_kick_core mspk_checker u_mspk_checker (.*);
